/* sv/b2y_pkg.sv */
// ============================================================================
// b2y_pkg
// Shared constants, types and helpers for the BGRA to YUV 4:2:0 converter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package b2y_pkg;

    // Largest frame dimension the raster counters support
    localparam int MAX_DIM = 4096;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 13;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int EFF_W      = CNT_W + 1;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register map, selected by paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

    // Pixel as packed on tdata: blue lowest, red highest
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    // Converted sample as packed on tdata: luma lowest
    typedef struct packed {
        logic [PIX_W-1:0] chroma_blue_diff;
        logic [PIX_W-1:0] chroma_red_diff;
        logic [PIX_W-1:0] luma;
    } yuv_t;

    // Raster position flags for one pixel
    typedef struct packed {
        logic chroma_valid;
        logic row_end;
        logic frame_end;
    } pos_flags_t;

    // Effective dimension: zero acts as one, oversize clamps to MAX_DIM
    function automatic logic [EFF_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [EFF_W-1:0] r;
        if (v == '0)
            r = EFF_W'(1);
        else if (32'(v) > 32'(MAX_DIM))
            r = EFF_W'(MAX_DIM);
        else
            r = EFF_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/b2y_apb_regs.sv */
// ============================================================================
// b2y_apb_regs
// APB register block holding the frame width and height.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module b2y_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [b2y_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [b2y_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [b2y_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output logic      [b2y_pkg::DIM_W-1:0]         frame_width,
    output logic      [b2y_pkg::DIM_W-1:0]         frame_height
);

    logic [b2y_pkg::DIM_W-1:0] frame_width_reg;
    logic [b2y_pkg::DIM_W-1:0] frame_height_reg;
    logic                      wr_en;

    // No wait states
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= b2y_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= b2y_pkg::FRAME_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                b2y_pkg::REG_FRAME_WIDTH:
                    frame_width_reg  <= pwdata[b2y_pkg::DIM_W-1:0];
                b2y_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[b2y_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[2])
            b2y_pkg::REG_FRAME_WIDTH:
                prdata = b2y_pkg::APB_DATA_W'(frame_width_reg);
            b2y_pkg::REG_FRAME_HEIGHT:
                prdata = b2y_pkg::APB_DATA_W'(frame_height_reg);
            default:
                prdata = '0;
        endcase
    end

    assign frame_width  = frame_width_reg;
    assign frame_height = frame_height_reg;

endmodule

`default_nettype wire

/* sv/b2y_raster.sv */
// ============================================================================
// b2y_raster
// Column and row counters; flags chroma sites, end of row and end of frame.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module b2y_raster (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [b2y_pkg::DIM_W-1:0]     frame_width,
    input  wire logic [b2y_pkg::DIM_W-1:0]     frame_height,
    output b2y_pkg::pos_flags_t                flags
);

    logic [b2y_pkg::CNT_W-1:0] col_reg;
    logic [b2y_pkg::CNT_W-1:0] col_next;
    logic [b2y_pkg::CNT_W-1:0] row_reg;
    logic [b2y_pkg::CNT_W-1:0] row_next;
    logic [b2y_pkg::EFF_W-1:0] width_eff;
    logic [b2y_pkg::EFF_W-1:0] height_eff;
    logic                      row_end;
    logic                      frame_end;

    assign width_eff  = b2y_pkg::eff_dim(frame_width);
    assign height_eff = b2y_pkg::eff_dim(frame_height);

    // At or beyond the last column / row ends the run
    assign row_end   = (b2y_pkg::EFF_W'(col_reg) + b2y_pkg::EFF_W'(1)) >= width_eff;
    assign frame_end = row_end &&
                       ((b2y_pkg::EFF_W'(row_reg) + b2y_pkg::EFF_W'(1)) >= height_eff);

    // Chroma sampled on odd rows, even columns
    assign flags.chroma_valid = row_reg[0] && !col_reg[0];
    assign flags.row_end      = row_end;
    assign flags.frame_end    = frame_end;

    // Next position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + b2y_pkg::CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + b2y_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // End of row always restarts the column count
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && row_end |=> col_reg == '0)
        else $error("column count not cleared after end of row");

    // End of frame returns to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_end |=> (col_reg == '0) && (row_reg == '0))
        else $error("position not cleared after end of frame");

endmodule

`default_nettype wire

/* sv/b2y_colour.sv */
// ============================================================================
// b2y_colour
// BT.601 limited-range colour conversion of one registered pixel.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module b2y_colour (
    input  wire b2y_pkg::pixel_t    pixel,
    input  wire logic               chroma_valid,
    output b2y_pkg::yuv_t           yuv
);

    logic        [16:0] luma_sum;
    logic signed [17:0] r_s;
    logic signed [17:0] g_s;
    logic signed [17:0] b_s;
    logic signed [17:0] cr_sum;
    logic signed [17:0] cb_sum;

    // Luma: unsigned weighted sum, rounded
    assign luma_sum = 17'd66  * 17'(pixel.red)
                    + 17'd129 * 17'(pixel.green)
                    + 17'd25  * 17'(pixel.blue)
                    + 17'd128;

    assign yuv.luma = luma_sum[15:8] + 8'd16;

    // Colour differences: signed sums, stay within 16-bit range
    assign r_s = $signed(18'(pixel.red));
    assign g_s = $signed(18'(pixel.green));
    assign b_s = $signed(18'(pixel.blue));

    assign cr_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;
    assign cb_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;

    // Floor shift by 8 plus 128 is the high byte with its top bit flipped
    assign yuv.chroma_red_diff  = chroma_valid ? {~cr_sum[15], cr_sum[14:8]} : '0;
    assign yuv.chroma_blue_diff = chroma_valid ? {~cb_sum[15], cb_sum[14:8]} : '0;

endmodule

`default_nettype wire

/* sv/bgra_to_yuv420_pixel_converter.sv */
// ============================================================================
// bgra_to_yuv420_pixel_converter
// Converts a raster pixel stream to BT.601 luma with 4:2:0 chroma sites.
// ============================================================================
// Pipeline: input register, then result register holding the converted
// sample.
// Throughput: one pixel per cycle unless m_axis_tready stalls; while a result
// waits in the output register, one more pixel can still enter an empty input register.
// Reset: asynchronous, active low; clears counters and pipeline valids and
// loads frame width 640 and height 480.
`timescale 1ns / 1ps
`default_nettype none

module bgra_to_yuv420_pixel_converter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Pixel input
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,  // blue, green, red
    // Converted output
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [23:0]                       m_axis_tdata,  // luma, cr, cb
    output logic                                   m_axis_tlast,  // end of row
    output logic      [1:0]                        m_axis_tuser,  // chroma_valid, frame_end
    // Configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [b2y_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [b2y_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [b2y_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    logic [b2y_pkg::DIM_W-1:0] frame_width;
    logic [b2y_pkg::DIM_W-1:0] frame_height;
    logic                      in_accept;
    logic                      out_ready;
    b2y_pkg::pos_flags_t       pos_flags;
    b2y_pkg::yuv_t             yuv;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    b2y_pkg::pixel_t           s1_pixel_reg;
    b2y_pkg::pos_flags_t       s1_flags_reg;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    b2y_pkg::yuv_t             m_yuv_reg;
    b2y_pkg::pos_flags_t       m_flags_reg;

    b2y_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    b2y_raster u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_accept),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .flags        (pos_flags)
    );

    b2y_colour u_colour (
        .pixel        (s1_pixel_reg),
        .chroma_valid (s1_flags_reg.chroma_valid),
        .yuv          (yuv)
    );

    // Handshake: output register frees when empty or taken
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next = in_accept || (s1_valid_reg && !out_ready);
    assign m_valid_next  = out_ready ? s1_valid_reg : m_valid_reg;

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= b2y_pkg::pixel_t'(s_axis_tdata);
            s1_flags_reg <= pos_flags;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            m_yuv_reg   <= yuv;
            m_flags_reg <= s1_flags_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_yuv_reg;
    assign m_axis_tlast    = m_flags_reg.row_end;
    assign m_axis_tuser[0] = m_flags_reg.chroma_valid;
    assign m_axis_tuser[1] = m_flags_reg.frame_end;

    // End of frame is always also end of row
    a_frame_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("frame end without row end");

    // Chroma bytes are zero away from chroma sites
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:8] == '0)
        else $error("chroma bytes set without chroma site");

    // An empty output stage never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // A pixel held in the input stage reaches the output stage next cycle when the output register frees
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_ready |=> m_valid_reg)
        else $error("pixel lost between stages");

endmodule

`default_nettype wire
